/* rtl/xy_lattice_metropolis_engine_unit_macros.svh */
// Assertion macros shared by the lattice engine RTL.
// Relies on clk and rst_n being in scope at the point of use.
`ifndef XY_LATTICE_METROPOLIS_ENGINE_UNIT_MACROS_SVH
`define XY_LATTICE_METROPOLIS_ENGINE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define XLME_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define XLME_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define XLME_ASSERT_SAME(label, ante, cons)
`define XLME_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* rtl/xlme_pkg.sv */
// Shared constants, types and tables for the XY lattice Metropolis engine.
// No dependencies.
package xlme_pkg;

    localparam int SIDE_BITS    = 6;
    localparam int ADDR_BITS    = 2 * SIDE_BITS;
    localparam int SITES        = 1 << ADDR_BITS;
    localparam int ANGLE_BITS   = 16;
    localparam int CORDIC_STEPS = 14;
    localparam int STEP_BITS    = 4;
    localparam int CORE_W       = 18;
    localparam int TRIG_W       = 17;
    localparam int MUL_W        = 33;
    localparam int PROD_W       = 2 * MUL_W;
    localparam int DELTA_W      = 20;
    localparam int MAG_W        = 17;
    localparam int SUM_W        = ADDR_BITS + TRIG_W;
    localparam int Y_W          = 37;
    // a fully aligned lattice squares to exactly 2^54
    localparam int SQ_W         = 55;
    localparam int MAG_SHIFT    = 2 * ADDR_BITS + 14;
    localparam int READ_SLOTS   = 5;

    localparam logic signed [CORE_W-1:0] CORDIC_START = 18'sd19898;
    localparam logic signed [CORE_W-1:0] TRIG_ONE     = 18'sd32768;
    localparam logic signed [MUL_W-1:0]  LOG2E_Q16    = 33'sd94548;
    localparam logic signed [MUL_W-1:0]  ONE_Q30      = 33'sd1073741824;
    localparam logic signed [MUL_W-1:0]  HORNER_START = 33'sd165394;
    localparam logic [4:0]               EXP_BASE_SHIFT = 5'd14;
    localparam int                       EXP_N_LIMIT  = 17;
    localparam logic [MAG_W-1:0]         MAG_LIMIT    = 17'd65536;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_TRIAL = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    typedef logic [ANGLE_BITS-1:0]    angle_t;
    typedef logic signed [TRIG_W-1:0] trig_t;

    typedef struct packed {
        logic  done;
        trig_t cos_v;
        trig_t sin_v;
    } trig_res_t;

    // arctangent of 2^-i in 16-bit phase units
    function automatic logic signed [CORE_W-1:0] rot_angle(input logic [STEP_BITS-1:0] i);
        logic signed [CORE_W-1:0] r;
        unique case (i)
            4'd0:    r = 18'sd8192;
            4'd1:    r = 18'sd4836;
            4'd2:    r = 18'sd2555;
            4'd3:    r = 18'sd1297;
            4'd4:    r = 18'sd651;
            4'd5:    r = 18'sd326;
            4'd6:    r = 18'sd163;
            4'd7:    r = 18'sd81;
            4'd8:    r = 18'sd41;
            4'd9:    r = 18'sd20;
            4'd10:   r = 18'sd10;
            4'd11:   r = 18'sd5;
            4'd12:   r = 18'sd3;
            4'd13:   r = 18'sd1;
            default: r = 18'sd0;
        endcase
        return r;
    endfunction

    // Horner coefficients of 2^-f, highest order first, then the constant one
    function automatic logic signed [MUL_W-1:0] horner_coef(input logic [2:0] k);
        logic signed [MUL_W-1:0] c;
        unique case (k)
            3'd0:    c = 33'sd1431684;
            3'd1:    c = 33'sd10327388;
            3'd2:    c = 33'sd59597084;
            3'd3:    c = 33'sd257941252;
            3'd4:    c = 33'sd744261118;
            default: c = ONE_Q30;
        endcase
        return c;
    endfunction

endpackage

/* rtl/xlme_mul.sv */
// Shared signed multiplier with a registered product.
// Depends on xlme_pkg.
module xlme_mul (
    input  logic                                clk,
    input  logic signed [xlme_pkg::MUL_W-1:0]   a,
    input  logic signed [xlme_pkg::MUL_W-1:0]   b,
    output logic signed [xlme_pkg::PROD_W-1:0]  p
);

    logic signed [xlme_pkg::PROD_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= xlme_pkg::PROD_W'(a) * xlme_pkg::PROD_W'(b);
    end

    assign p = p_reg;

endmodule

/* rtl/xlme_cordic.sv */
// Iterative rotation CORDIC: cos and sin of a 16-bit phase, one step a cycle.
// Depends on xlme_pkg.
module xlme_cordic (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  xlme_pkg::angle_t     phase,
    output xlme_pkg::trig_res_t  res
);

    logic signed [xlme_pkg::CORE_W-1:0] x_reg, y_reg, z_reg;
    logic signed [xlme_pkg::CORE_W-1:0] x_next, y_next, z_next;
    logic [xlme_pkg::STEP_BITS-1:0]     step_reg, step_next;
    logic                               busy_reg, busy_next;
    logic                               done_reg, done_next;
    logic                               flip_reg, flip_next;

    logic                               flip_in;
    xlme_pkg::angle_t                   folded;
    logic signed [xlme_pkg::CORE_W-1:0] dx, dy, rot;
    logic signed [xlme_pkg::CORE_W-1:0] xc, yc;

    // second and third quadrant fold onto the first and fourth by a half turn
    assign flip_in = phase[xlme_pkg::ANGLE_BITS-1] ^ phase[xlme_pkg::ANGLE_BITS-2];
    assign folded  = flip_in ? (phase ^ {1'b1, {(xlme_pkg::ANGLE_BITS-1){1'b0}}}) : phase;
    assign dx      = y_reg >>> step_reg;
    assign dy      = x_reg >>> step_reg;
    assign rot     = xlme_pkg::rot_angle(step_reg);

    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        flip_next = flip_reg;
        done_next = 1'b0;
        if (start)
        begin
            x_next    = xlme_pkg::CORDIC_START;
            y_next    = '0;
            z_next    = xlme_pkg::CORE_W'($signed(folded));
            step_next = '0;
            busy_next = 1'b1;
            flip_next = flip_in;
        end
        else if (busy_reg)
        begin
            if (!z_reg[xlme_pkg::CORE_W-1])
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - rot;
            end
            else
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + rot;
            end
            step_next = step_reg + 1'b1;
            if (step_reg == xlme_pkg::STEP_BITS'(xlme_pkg::CORDIC_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        flip_reg <= flip_next;
    end

    always_comb
    begin
        xc = x_reg;
        yc = y_reg;
        if (xc > xlme_pkg::TRIG_ONE)  xc = xlme_pkg::TRIG_ONE;
        if (xc < -xlme_pkg::TRIG_ONE) xc = -xlme_pkg::TRIG_ONE;
        if (yc > xlme_pkg::TRIG_ONE)  yc = xlme_pkg::TRIG_ONE;
        if (yc < -xlme_pkg::TRIG_ONE) yc = -xlme_pkg::TRIG_ONE;
        if (flip_reg)
        begin
            xc = -xc;
            yc = -yc;
        end
    end

    assign res.done  = done_reg;
    assign res.cos_v = xc[xlme_pkg::TRIG_W-1:0];
    assign res.sin_v = yc[xlme_pkg::TRIG_W-1:0];

endmodule

/* rtl/xy_lattice_metropolis_engine_unit.sv */
// XY lattice Metropolis engine: 64x64 periodic lattice of 16-bit spin phases.
// Requests come in on in_valid/in_ready with command, row, column,
// proposed_angle and uniform_draw; one result per request leaves on
// out_valid/out_ready as accepted, energy_change and magnetization.
// inverse_temperature (Q8.8), reset to 256, is written through cfg_write_en/
// cfg_write_data by the user only while idle; the block does not enforce it.
// Work per request, on the lattice memory (one read and one write port) and
// the shared 14-step CORDIC:
//   write: one memory write; unused command: straight to the result.
//   trial: five lattice reads, eight cosines, and where needed the
//          Boltzmann factor on the shared multiplier.
//   magnetization query: a read and a cosine and sine for every site.
// One request is worked at a time; in_ready is high only while idle.
// After reset the lattice is swept to zero, one site a cycle over all 4096
// sites, during which no request is taken.
// A finished result sits in the output register until taken; the next
// request may be accepted meanwhile, and its result waits if out_ready is low.
module xy_lattice_metropolis_engine_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write_en,
    input  logic [15:0]                           cfg_write_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [1:0]                            command,
    input  logic [xlme_pkg::SIDE_BITS-1:0]        row,
    input  logic [xlme_pkg::SIDE_BITS-1:0]        column,
    input  logic [15:0]                           proposed_angle,
    input  logic [15:0]                           uniform_draw,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  accepted,
    output logic signed [xlme_pkg::DELTA_W-1:0]   energy_change,
    output logic [xlme_pkg::MAG_W-1:0]            magnetization
);

`include "xy_lattice_metropolis_engine_unit_macros.svh"

    localparam logic [4:0] S_CLEAR = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_WR    = 5'd2;
    localparam logic [4:0] S_TRD   = 5'd3;
    localparam logic [4:0] S_TCS   = 5'd4;
    localparam logic [4:0] S_TCW   = 5'd5;
    localparam logic [4:0] S_TDEC  = 5'd6;
    localparam logic [4:0] S_BM0   = 5'd7;
    localparam logic [4:0] S_BM1   = 5'd8;
    localparam logic [4:0] S_BM2   = 5'd9;
    localparam logic [4:0] S_BM3   = 5'd10;
    localparam logic [4:0] S_BN    = 5'd11;
    localparam logic [4:0] S_HMUL  = 5'd12;
    localparam logic [4:0] S_HADD  = 5'd13;
    localparam logic [4:0] S_BF    = 5'd14;
    localparam logic [4:0] S_TWB   = 5'd15;
    localparam logic [4:0] S_QRD   = 5'd16;
    localparam logic [4:0] S_QCS   = 5'd17;
    localparam logic [4:0] S_QCW   = 5'd18;
    localparam logic [4:0] S_QSQ0  = 5'd19;
    localparam logic [4:0] S_QSQ1  = 5'd20;
    localparam logic [4:0] S_QSQ2  = 5'd21;
    localparam logic [4:0] S_FIN   = 5'd22;

    localparam int AB = xlme_pkg::ADDR_BITS;
    localparam int SB = xlme_pkg::SIDE_BITS;

    logic [4:0] state_reg, state_next;
    logic [AB-1:0] idx_reg, idx_next;

    logic [15:0] beta_reg;

    logic [1:0]             cmd_reg, cmd_next;
    logic [SB-1:0]          row_reg, row_next, col_reg, col_next;
    xlme_pkg::angle_t       ang_reg, ang_next, draw_reg, draw_next;
    xlme_pkg::angle_t       old_reg, old_next;
    xlme_pkg::angle_t       nb_reg [4];
    xlme_pkg::angle_t       nb_next [4];
    logic [2:0]             term_reg, term_next;
    logic signed [xlme_pkg::DELTA_W-1:0] delta_reg, delta_next;
    logic [17:0]            plo_reg, plo_next;
    logic [34:0]            ph_reg, ph_next;
    logic [xlme_pkg::Y_W-1:0] y_reg, y_next;
    logic [4:0]             n_reg, n_next;
    logic signed [xlme_pkg::MUL_W-1:0] acc_reg, acc_next;
    logic [2:0]             hstep_reg, hstep_next;
    logic signed [xlme_pkg::SUM_W-1:0] sc_reg, sc_next, ss_reg, ss_next;
    logic [xlme_pkg::SQ_W-1:0] sq_reg, sq_next;

    logic                   res_acc_reg, res_acc_next;
    logic signed [xlme_pkg::DELTA_W-1:0] res_energy_reg, res_energy_next;
    logic [xlme_pkg::MAG_W-1:0] res_mag_reg, res_mag_next;

    logic                   out_valid_reg, out_valid_next;
    logic                   out_acc_reg, out_acc_next;
    logic signed [xlme_pkg::DELTA_W-1:0] out_energy_reg, out_energy_next;
    logic [xlme_pkg::MAG_W-1:0] out_mag_reg, out_mag_next;

    // lattice memory
    xlme_pkg::angle_t       lattice_mem [xlme_pkg::SITES];
    xlme_pkg::angle_t       rd_data_reg;
    logic                   mem_we;
    logic [AB-1:0]          mem_waddr, mem_raddr;
    xlme_pkg::angle_t       mem_wdata;

    // shared units
    logic                   trig_start;
    xlme_pkg::angle_t       trig_phase;
    xlme_pkg::trig_res_t    trig;
    logic signed [xlme_pkg::MUL_W-1:0]  mul_a, mul_b;
    logic signed [xlme_pkg::PROD_W-1:0] mul_p;

    logic [AB-1:0]          site_addr;
    logic signed [xlme_pkg::SUM_W-1:0] abs_sc, abs_ss;
    logic [52:0]            y_sum;
    logic signed [xlme_pkg::PROD_W-1:0] horner_t;
    logic [31:0]            acc_pos, factor;
    logic [4:0]             exp_shift;
    logic [xlme_pkg::SQ_W:0] num;
    logic [xlme_pkg::MAG_W:0] q;
    logic [1:0]             slot;

    assign site_addr = {row_reg, col_reg};
    assign abs_sc    = sc_reg[xlme_pkg::SUM_W-1] ? -sc_reg : sc_reg;
    assign abs_ss    = ss_reg[xlme_pkg::SUM_W-1] ? -ss_reg : ss_reg;
    assign y_sum     = {ph_reg, 18'b0} + 53'(mul_p[34:0]);
    assign horner_t  = mul_p >>> 30;
    assign acc_pos   = acc_reg[xlme_pkg::MUL_W-1] ? 32'd0 : acc_reg[31:0];
    assign exp_shift = xlme_pkg::EXP_BASE_SHIFT + n_reg;
    assign factor    = acc_pos >> exp_shift;
    assign num       = (xlme_pkg::SQ_W+1)'(sq_reg)
                       + (xlme_pkg::SQ_W+1)'(mul_p[xlme_pkg::SQ_W-1:0]);
    assign q         = num[xlme_pkg::SQ_W:xlme_pkg::MAG_SHIFT];
    assign slot      = 2'(idx_reg[2:0] - 3'd2);

    assign trig_start = (state_reg == S_TCS) || (state_reg == S_QCS);
    assign trig_phase = (state_reg == S_QCS) ? rd_data_reg :
                        ((term_reg[0] ? ang_reg : old_reg) - nb_reg[term_reg[2:1]]);

    xlme_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (trig_start),
        .phase (trig_phase),
        .res   (trig)
    );

    xlme_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    always_ff @(posedge clk)
    begin
        if (mem_we)
            lattice_mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= lattice_mem[mem_raddr];
    end

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        cmd_next        = cmd_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        ang_next        = ang_reg;
        draw_next       = draw_reg;
        old_next        = old_reg;
        nb_next         = nb_reg;
        term_next       = term_reg;
        delta_next      = delta_reg;
        plo_next        = plo_reg;
        ph_next         = ph_reg;
        y_next          = y_reg;
        n_next          = n_reg;
        acc_next        = acc_reg;
        hstep_next      = hstep_reg;
        sc_next         = sc_reg;
        ss_next         = ss_reg;
        sq_next         = sq_reg;
        res_acc_next    = res_acc_reg;
        res_energy_next = res_energy_reg;
        res_mag_next    = res_mag_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_acc_next    = out_acc_reg;
        out_energy_next = out_energy_reg;
        out_mag_next    = out_mag_reg;
        mem_we          = 1'b0;
        mem_waddr       = site_addr;
        mem_wdata       = ang_reg;
        mem_raddr       = site_addr;
        mul_a           = '0;
        mul_b           = '0;
        in_ready        = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                mem_wdata = '0;
                idx_next  = idx_reg + 1'b1;
                if (idx_reg == AB'(xlme_pkg::SITES - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd_next        = command;
                    row_next        = row;
                    col_next        = column;
                    ang_next        = proposed_angle;
                    draw_next       = uniform_draw;
                    res_acc_next    = 1'b0;
                    res_energy_next = '0;
                    res_mag_next    = '0;
                    idx_next        = '0;
                    delta_next      = '0;
                    term_next       = '0;
                    sc_next         = '0;
                    ss_next         = '0;
                    unique case (command)
                        xlme_pkg::CMD_WRITE:
                        begin
                            res_acc_next = 1'b1;
                            state_next   = S_WR;
                        end
                        xlme_pkg::CMD_TRIAL: state_next = S_TRD;
                        xlme_pkg::CMD_QUERY: state_next = S_QRD;
                        default:             state_next = S_FIN;
                    endcase
                end
            end
            S_WR:
            begin
                mem_we     = 1'b1;
                state_next = S_FIN;
            end
            S_TRD:
            begin
                // site, then up, down, left, right; each read's data lands in the next cycle
                unique case (idx_reg[2:0])
                    3'd1:    mem_raddr = {SB'(row_reg - 1'b1), col_reg};
                    3'd2:    mem_raddr = {SB'(row_reg + 1'b1), col_reg};
                    3'd3:    mem_raddr = {row_reg, SB'(col_reg - 1'b1)};
                    3'd4:    mem_raddr = {row_reg, SB'(col_reg + 1'b1)};
                    default: mem_raddr = site_addr;
                endcase
                if (idx_reg[2:0] == 3'd1)
                    old_next = rd_data_reg;
                else if (idx_reg[2:0] != 3'd0)
                    nb_next[slot] = rd_data_reg;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == AB'(xlme_pkg::READ_SLOTS))
                    state_next = S_TCS;
            end
            S_TCS:
            begin
                state_next = S_TCW;
            end
            S_TCW:
            begin
                if (trig.done)
                begin
                    if (term_reg[0])
                        delta_next = delta_reg - xlme_pkg::DELTA_W'(trig.cos_v);
                    else
                        delta_next = delta_reg + xlme_pkg::DELTA_W'(trig.cos_v);
                    term_next  = term_reg + 1'b1;
                    state_next = (term_reg == 3'd7) ? S_TDEC : S_TCS;
                end
            end
            S_TDEC:
            begin
                res_energy_next = delta_reg;
                if (delta_reg[xlme_pkg::DELTA_W-1])
                begin
                    res_acc_next = 1'b1;
                    state_next   = S_TWB;
                end
                else
                    state_next = S_BM0;
            end
            S_BM0:
            begin
                mul_a      = xlme_pkg::MUL_W'(delta_reg);
                mul_b      = $signed(xlme_pkg::MUL_W'(beta_reg));
                state_next = S_BM1;
            end
            S_BM1:
            begin
                // delta*beta split in halves so each product stays narrow
                mul_a      = $signed(xlme_pkg::MUL_W'(mul_p[35:18]));
                mul_b      = xlme_pkg::LOG2E_Q16;
                plo_next   = mul_p[17:0];
                state_next = S_BM2;
            end
            S_BM2:
            begin
                mul_a      = $signed(xlme_pkg::MUL_W'(plo_reg));
                mul_b      = xlme_pkg::LOG2E_Q16;
                ph_next    = mul_p[34:0];
                state_next = S_BM3;
            end
            S_BM3:
            begin
                y_next     = y_sum[52:16];
                state_next = S_BN;
            end
            S_BN:
            begin
                if (y_reg[xlme_pkg::Y_W-1:23] >= 14'(xlme_pkg::EXP_N_LIMIT))
                begin
                    // factor underflows to zero
                    res_acc_next = (draw_reg == '0);
                    state_next   = S_TWB;
                end
                else
                begin
                    n_next     = y_reg[27:23];
                    acc_next   = xlme_pkg::HORNER_START;
                    hstep_next = '0;
                    state_next = S_HMUL;
                end
            end
            S_HMUL:
            begin
                mul_a      = acc_reg;
                mul_b      = $signed(xlme_pkg::MUL_W'({y_reg[22:0], 7'b0}));
                state_next = S_HADD;
            end
            S_HADD:
            begin
                acc_next   = xlme_pkg::horner_coef(hstep_reg)
                             - horner_t[xlme_pkg::MUL_W-1:0];
                hstep_next = hstep_reg + 1'b1;
                state_next = (hstep_reg == 3'd5) ? S_BF : S_HMUL;
            end
            S_BF:
            begin
                res_acc_next = ({16'b0, draw_reg} <= factor);
                state_next   = S_TWB;
            end
            S_TWB:
            begin
                mem_we     = res_acc_reg;
                state_next = S_FIN;
            end
            S_QRD:
            begin
                mem_raddr  = idx_reg;
                state_next = S_QCS;
            end
            S_QCS:
            begin
                state_next = S_QCW;
            end
            S_QCW:
            begin
                if (trig.done)
                begin
                    sc_next  = sc_reg + xlme_pkg::SUM_W'(trig.cos_v);
                    ss_next  = ss_reg + xlme_pkg::SUM_W'(trig.sin_v);
                    idx_next = idx_reg + 1'b1;
                    state_next = (idx_reg == AB'(xlme_pkg::SITES - 1)) ? S_QSQ0 : S_QRD;
                end
            end
            S_QSQ0:
            begin
                mul_a      = xlme_pkg::MUL_W'(abs_sc);
                mul_b      = xlme_pkg::MUL_W'(abs_sc);
                state_next = S_QSQ1;
            end
            S_QSQ1:
            begin
                mul_a      = xlme_pkg::MUL_W'(abs_ss);
                mul_b      = xlme_pkg::MUL_W'(abs_ss);
                sq_next    = mul_p[xlme_pkg::SQ_W-1:0];
                state_next = S_QSQ2;
            end
            S_QSQ2:
            begin
                res_mag_next = (q > xlme_pkg::MAG_LIMIT) ? xlme_pkg::MAG_LIMIT
                                                         : q[xlme_pkg::MAG_W-1:0];
                state_next   = S_FIN;
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_acc_next    = res_acc_reg;
                    out_energy_next = res_energy_reg;
                    out_mag_next    = res_mag_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            beta_reg      <= 16'd256;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write_en)
                beta_reg <= cfg_write_data;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        row_reg        <= row_next;
        col_reg        <= col_next;
        ang_reg        <= ang_next;
        draw_reg       <= draw_next;
        old_reg        <= old_next;
        nb_reg         <= nb_next;
        term_reg       <= term_next;
        delta_reg      <= delta_next;
        plo_reg        <= plo_next;
        ph_reg         <= ph_next;
        y_reg          <= y_next;
        n_reg          <= n_next;
        acc_reg        <= acc_next;
        hstep_reg      <= hstep_next;
        sc_reg         <= sc_next;
        ss_reg         <= ss_next;
        sq_reg         <= sq_next;
        res_acc_reg    <= res_acc_next;
        res_energy_reg <= res_energy_next;
        res_mag_reg    <= res_mag_next;
        out_acc_reg    <= out_acc_next;
        out_energy_reg <= out_energy_next;
        out_mag_reg    <= out_mag_next;
    end

    assign out_valid     = out_valid_reg;
    assign accepted      = out_acc_reg;
    assign energy_change = out_energy_reg;
    assign magnetization = out_mag_reg;

    `XLME_ASSERT_SAME(a_mem_write_state, mem_we,
        state_reg == S_CLEAR || state_reg == S_WR || state_reg == S_TWB)
    `XLME_ASSERT_SAME(a_trig_done_waited, trig.done,
        state_reg == S_TCW || state_reg == S_QCW)
    `XLME_ASSERT_SAME(a_downhill_taken,
        state_reg == S_TWB && cmd_reg == xlme_pkg::CMD_TRIAL && delta_reg[xlme_pkg::DELTA_W-1],
        res_acc_reg)
    `XLME_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready)

endmodule
